// File: design/assert_macros.svh
// Assertion helpers for the text console writer.
// Both macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is held
`define ASSERT_RST(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error("assertion failed");

// Clocked check that also covers reset cycles
`define ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) else $error("assertion failed");

`else

`define ASSERT_RST(lbl, clk_s, rst_s, prop)

`define ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

// File: design/tcw_pkg.sv
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Character codes
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  // Attribute reset values
  localparam logic [7:0] TEXT_ATTR_RST  = 8'h0F;
  localparam logic [7:0] BLANK_ATTR_RST = 8'h07;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'b1;

  // Request operations
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // One screen cell: attribute in the high byte, character in the low byte
  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

endpackage

// File: design/text_console_writer.sv
// Put, read and unused-code requests pass through ST_DONE, which registers the result; one request at a time.
// Clear: ST_FILL blanks the screen, one cell write per cycle on the single screen RAM write port.
// A put that scrolls goes through ST_SCROLL_PRIME, which fetches the first cell of row 1,
// then ST_SCROLL and ST_FILL, one cell moved or blanked per cycle.
// After reset the screen RAM is swept to blank cells in ST_INIT,
// with in_stall high; configuration writes are taken throughout.
// Reset is synchronous, active low; the cursor homes and the attributes take 0x0F / 0x07.
`include "assert_macros.svh"

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_wdata,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_operation,
  input  logic [7:0]                     in_char_code,
  input  logic [10:0]                    in_cell_index,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [10:0]                    out_cursor_position,
  output logic [7:0]                     out_cell_char,
  output logic [7:0]                     out_cell_attr
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int PW         = $clog2(CELL_COUNT + 1);
  localparam int CW         = $clog2(COLUMNS);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_SCROLL_PRIME,
    ST_SCROLL,
    ST_DONE
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       scan_r;
  logic [CW-1:0]       col_r;
  logic [AW-1:0]       pos_r;
  logic [7:0]          text_attr_r;
  logic [7:0]          blank_attr_r;
  logic                read_hit_r;
  logic                out_valid_r;
  logic [10:0]         out_cursor_position_r;
  logic [7:0]          out_cell_char_r;
  logic [7:0]          out_cell_attr_r;

  // screen RAM
  tcw_pkg::cell_t      mem [CELL_COUNT];
  tcw_pkg::cell_t      rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  tcw_pkg::cell_t      mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;

  tcw_pkg::op_t        op;
  logic                in_accept;
  logic                read_hit;

  // cursor update for a put request
  logic [CW-1:0]       put_col;
  logic [PW-1:0]       put_pos;
  logic                put_we;
  logic [AW-1:0]       put_addr;
  tcw_pkg::cell_t      put_data;
  logic                put_scroll;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign op        = tcw_pkg::op_t'(in_operation);
  assign read_hit  = (op == tcw_pkg::OP_READ) && (32'(in_cell_index) < 32'(CELL_COUNT));

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_cursor_position_r;
  assign out_cell_char       = out_cell_char_r;
  assign out_cell_attr       = out_cell_attr_r;

  // Put: newline, backspace or any other byte; linear position tracks the column
  always_comb begin
    put_col  = col_r;
    put_pos  = PW'(pos_r);
    put_we   = 1'b0;
    put_addr = pos_r;
    put_data = {text_attr_r, in_char_code};
    if (in_char_code == tcw_pkg::CH_NEWLINE) begin
      put_col = '0;
      put_pos = PW'(pos_r) - PW'(col_r) + PW'(COLUMNS);
    end else if (in_char_code == tcw_pkg::CH_BACKSPACE) begin
      if (col_r != '0) begin
        put_col  = col_r - CW'(1);
        put_pos  = PW'(pos_r) - PW'(1);
        put_we   = 1'b1;
        put_addr = pos_r - AW'(1);
        put_data = {blank_attr_r, tcw_pkg::CH_SPACE};
      end
    end else begin
      put_we  = 1'b1;
      put_col = (col_r == CW'(COLUMNS - 1)) ? '0 : col_r + CW'(1);
      put_pos = PW'(pos_r) + PW'(1);
    end
  end

  assign put_scroll = (put_pos >= PW'(CELL_COUNT));

  // RAM port control from the sequencer
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_r;
    mem_wdata = {blank_attr_r, tcw_pkg::CH_SPACE};
    mem_re    = 1'b0;
    mem_raddr = AW'(in_cell_index);
    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {tcw_pkg::BLANK_ATTR_RST, tcw_pkg::CH_SPACE};
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (op == tcw_pkg::OP_PUT) begin
            mem_we    = put_we;
            mem_waddr = put_addr;
            mem_wdata = put_data;
          end
          mem_re = read_hit;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_SCROLL_PRIME: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(COLUMNS);
      end
      ST_SCROLL: begin
        // write row above with the cell read in the previous cycle, fetch the next one
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        mem_re    = (scan_r != AW'(LAST_BASE - 1));
        mem_raddr = scan_r + AW'(COLUMNS + 1);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Screen RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Sequencer, cursor, config and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      scan_r       <= '0;
      col_r        <= '0;
      pos_r        <= '0;
      text_attr_r  <= tcw_pkg::TEXT_ATTR_RST;
      blank_attr_r <= tcw_pkg::BLANK_ATTR_RST;
      read_hit_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tcw_pkg::REG_TEXT_ATTR:  text_attr_r  <= cfg_wdata;
          tcw_pkg::REG_BLANK_ATTR: blank_attr_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // result taken; ST_DONE reloads it in the same cycle
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_INIT: begin
          scan_r <= scan_r + AW'(1);
          if (scan_r == AW'(CELL_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            read_hit_r <= read_hit;
            unique case (op)
              tcw_pkg::OP_PUT: begin
                col_r <= put_col;
                if (put_scroll) begin
                  pos_r   <= AW'(LAST_BASE);
                  state_r <= ST_SCROLL_PRIME;
                end else begin
                  pos_r   <= AW'(put_pos);
                  state_r <= ST_DONE;
                end
              end
              tcw_pkg::OP_CLEAR: begin
                col_r   <= '0;
                pos_r   <= '0;
                scan_r  <= '0;
                state_r <= ST_FILL;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_FILL: begin
          scan_r <= scan_r + AW'(1);
          if (scan_r == AW'(CELL_COUNT - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_SCROLL_PRIME: begin
          scan_r  <= '0;
          state_r <= ST_SCROLL;
        end
        ST_SCROLL: begin
          // counter runs on into the bottom row, which is then blanked
          scan_r <= scan_r + AW'(1);
          if (scan_r == AW'(LAST_BASE - 1)) begin
            state_r <= ST_FILL;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r           <= 1'b1;
            out_cursor_position_r <= 11'(pos_r);
            out_cell_char_r       <= read_hit_r ? rd_data_r.ch : 8'd0;
            out_cell_attr_r       <= read_hit_r ? rd_data_r.attr : 8'd0;
            state_r               <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_rst_stall, clk, !rst_n |=> in_stall)
  `ASSERT_RST(a_accept_busy, clk, rst_n, in_accept |=> in_stall)
  `ASSERT_RST(a_idle_write, clk, rst_n, (mem_we && state_r == ST_IDLE) |-> in_accept)
  `ASSERT_RST(a_cursor_range, clk, rst_n, (PW'(pos_r) < PW'(CELL_COUNT)) && (PW'(col_r) < PW'(COLUMNS)))

endmodule
